@@ src/spt_pkg.sv @@
package spt_pkg;

    localparam int CAPACITY   = 64;
    localparam int COORD_BITS = 16;
    localparam int IDX_W      = $clog2(CAPACITY);
    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int ENTRY_W    = 2 * COORD_BITS;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic [IDX_W-1:0]             idx_t;
    typedef logic [CNT_W-1:0]             cnt_t;
    typedef logic [ENTRY_W-1:0]           entry_t;

    localparam cnt_t CAPACITY_CNT = CNT_W'(CAPACITY);

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_READ   = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_NEG      = 3'd1,
        ST_NOTFOUND = 3'd2,
        ST_FULL     = 3'd3,
        ST_RANGE    = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS,
        S_PUT,
        S_DEL,
        S_READ,
        S_DONE
    } state_t;

    // Entries pack y in the upper half and x in the lower half.
    function automatic entry_t pack_point(coord_t x, coord_t y);
        return {y, x};
    endfunction

    function automatic coord_t entry_x(entry_t e);
        return coord_t'(e[COORD_BITS-1:0]);
    endfunction

    function automatic coord_t entry_y(entry_t e);
        return coord_t'(e[ENTRY_W-1:COORD_BITS]);
    endfunction

    // True when the stored point sorts at or after (x, y): by y, then by x.
    function automatic logic not_smaller(entry_t e, coord_t x, coord_t y);
        coord_t ex;
        coord_t ey;
        ex = entry_x(e);
        ey = entry_y(e);
        return (ey > y) || ((ey == y) && (ex >= x));
    endfunction

endpackage

@@ src/sorted_point_table.sv @@
// sorted_point_table: table of (x, y) points kept in ascending order by y,
// then by x, held in one 64-entry single-read, single-write memory.
//
// Request channel (req_valid / req_ready): op, px, py, read_index. A request
// is taken when both are high. Insert places the point ahead of the first
// entry that is not smaller; delete removes the first exact match; read
// returns the entry at read_index.
// Result channel (res_valid / res_ready): status, entry_count, rd_x, rd_y.
// Exactly one result per request, in request order.
//
// Insert walks down from the top entry and stops early when the point sorts
// high; delete walks up through every entry; read takes one memory read;
// rejected or trivial requests and inserts into an empty table go straight
// to the finish state. Insert and delete walk one entry per cycle (one read,
// one write a cycle). The next request can be taken in the cycle in which
// res_valid rises; one request is in flight at a time.
// Reset clears the entry count and the control state; the memory itself is
// not cleared, only entries below the count are ever read.
// A stalled receiver holds the result register; the next request is still
// taken and worked, and waits in the finish state until the register frees.
module sorted_point_table
    import spt_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,

    input  logic         req_valid,
    output logic         req_ready,
    input  logic [1:0]   op,
    input  coord_t       px,
    input  coord_t       py,
    input  idx_t         read_index,

    output logic         res_valid,
    input  logic         res_ready,
    output logic [2:0]   status,
    output cnt_t         entry_count,
    output coord_t       rd_x,
    output coord_t       rd_y
);

    // Point storage: synchronous read, registered read data.
    entry_t mem [CAPACITY];
    entry_t mem_rdata_reg;
    logic   mem_we;
    idx_t   mem_waddr;
    entry_t mem_wdata;
    logic   mem_re;
    idx_t   mem_raddr;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            mem_rdata_reg <= mem[mem_raddr];
        end
    end

    // Control state.
    state_t state_reg, state_next;
    cnt_t   count_reg, count_next;
    idx_t   ptr_reg, ptr_next;
    logic   found_reg, found_next;

    // Request captured at acceptance.
    coord_t x_reg;
    coord_t y_reg;

    // Finished result waiting for the output register.
    status_t hold_status_reg, hold_status_next;
    coord_t  hold_x_reg, hold_x_next;
    coord_t  hold_y_reg, hold_y_next;

    // Output register.
    logic    res_valid_reg, res_valid_next;
    status_t status_reg;
    cnt_t    count_out_reg;
    coord_t  rd_x_reg;
    coord_t  rd_y_reg;
    logic    out_load;

    logic    req_take;
    entry_t  rd_entry;
    entry_t  new_point;
    logic    is_last;
    logic    is_match;

    assign req_ready = (state_reg == S_IDLE);
    assign req_take  = req_valid && req_ready;
    assign rd_entry  = mem_rdata_reg;
    assign new_point = pack_point(x_reg, y_reg);
    assign is_last   = ((CNT_W'(ptr_reg) + CNT_W'(1)) == count_reg);
    assign is_match  = (rd_entry == new_point);

    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        ptr_next         = ptr_reg;
        found_next       = found_reg;
        hold_status_next = hold_status_reg;
        hold_x_next      = hold_x_reg;
        hold_y_next      = hold_y_reg;
        mem_we           = 1'b0;
        mem_waddr        = '0;
        mem_wdata        = '0;
        mem_re           = 1'b0;
        mem_raddr        = '0;
        out_load         = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    hold_status_next = ST_OK;
                    hold_x_next      = '0;
                    hold_y_next      = '0;
                    state_next       = S_DONE;
                    unique case (op_t'(op))
                        OP_INSERT:
                        begin
                            priority if (px[COORD_BITS-1] || py[COORD_BITS-1])
                            begin
                                hold_status_next = ST_NEG;
                            end
                            else if (count_reg == CAPACITY_CNT)
                            begin
                                hold_status_next = ST_FULL;
                            end
                            else if (count_reg == '0)
                            begin
                                // Empty table: store directly at the bottom.
                                mem_we     = 1'b1;
                                mem_waddr  = '0;
                                mem_wdata  = pack_point(px, py);
                                count_next = CNT_W'(1);
                            end
                            else
                            begin
                                // Walk down from the top entry.
                                mem_re     = 1'b1;
                                mem_raddr  = IDX_W'(count_reg - CNT_W'(1));
                                ptr_next   = IDX_W'(count_reg - CNT_W'(1));
                                state_next = S_INS;
                            end
                        end
                        OP_DELETE:
                        begin
                            if (count_reg == '0)
                            begin
                                hold_status_next = ST_NOTFOUND;
                            end
                            else
                            begin
                                mem_re     = 1'b1;
                                mem_raddr  = '0;
                                ptr_next   = '0;
                                found_next = 1'b0;
                                state_next = S_DEL;
                            end
                        end
                        OP_READ:
                        begin
                            if (CNT_W'(read_index) >= count_reg)
                            begin
                                hold_status_next = ST_RANGE;
                            end
                            else
                            begin
                                mem_re     = 1'b1;
                                mem_raddr  = read_index;
                                state_next = S_READ;
                            end
                        end
                        OP_NONE:
                        begin
                            hold_status_next = ST_OK;
                        end
                        default:
                        begin
                            hold_status_next = ST_OK;
                        end
                    endcase
                end
            end

            S_INS:
            begin
                if (not_smaller(rd_entry, x_reg, y_reg))
                begin
                    // Move this entry up one slot; keep walking down unless it was the bottom.
                    mem_we    = 1'b1;
                    mem_waddr = ptr_reg + IDX_W'(1);
                    mem_wdata = rd_entry;
                    if (ptr_reg == '0)
                    begin
                        state_next = S_PUT;
                    end
                    else
                    begin
                        mem_re    = 1'b1;
                        mem_raddr = ptr_reg - IDX_W'(1);
                        ptr_next  = ptr_reg - IDX_W'(1);
                    end
                end
                else
                begin
                    // First smaller entry found: drop the point just above it.
                    mem_we           = 1'b1;
                    mem_waddr        = ptr_reg + IDX_W'(1);
                    mem_wdata        = new_point;
                    count_next       = count_reg + CNT_W'(1);
                    hold_status_next = ST_OK;
                    state_next       = S_DONE;
                end
            end

            S_PUT:
            begin
                mem_we           = 1'b1;
                mem_waddr        = '0;
                mem_wdata        = new_point;
                count_next       = count_reg + CNT_W'(1);
                hold_status_next = ST_OK;
                state_next       = S_DONE;
            end

            S_DEL:
            begin
                // After the match, advance every entry down one slot.
                if (found_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = ptr_reg - IDX_W'(1);
                    mem_wdata = rd_entry;
                end
                found_next = found_reg || is_match;
                if (is_last)
                begin
                    if (found_reg || is_match)
                    begin
                        count_next       = count_reg - CNT_W'(1);
                        hold_status_next = ST_OK;
                    end
                    else
                    begin
                        hold_status_next = ST_NOTFOUND;
                    end
                    state_next = S_DONE;
                end
                else
                begin
                    mem_re    = 1'b1;
                    mem_raddr = ptr_reg + IDX_W'(1);
                    ptr_next  = ptr_reg + IDX_W'(1);
                end
            end

            S_READ:
            begin
                hold_status_next = ST_OK;
                hold_x_next      = entry_x(rd_entry);
                hold_y_next      = entry_y(rd_entry);
                state_next       = S_DONE;
            end

            S_DONE:
            begin
                // Hold until the output register is free.
                if (!res_valid_reg || res_ready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        priority if (out_load)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            ptr_reg       <= '0;
            found_reg     <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ptr_reg       <= ptr_next;
            found_reg     <= found_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_take)
        begin
            x_reg <= px;
            y_reg <= py;
        end
        hold_status_reg <= hold_status_next;
        hold_x_reg      <= hold_x_next;
        hold_y_reg      <= hold_y_next;
        if (out_load)
        begin
            status_reg    <= hold_status_reg;
            count_out_reg <= count_reg;
            rd_x_reg      <= hold_x_reg;
            rd_y_reg      <= hold_y_reg;
        end
    end

    assign res_valid   = res_valid_reg;
    assign status      = status_reg;
    assign entry_count = count_out_reg;
    assign rd_x        = rd_x_reg;
    assign rd_y        = rd_y_reg;

endmodule
